// ===== hw/rtl/sobs_pkg.sv =====
// Shared types, constants and helpers for the set of bounded stacks.
package sobs_pkg;

	localparam int MAX_STACKS   = 16;
	localparam int MAX_CAPACITY = 64;

	localparam int OP_W  = 2;
	localparam int VAL_W = 32;
	localparam int IDX_W = 5;
	localparam int ST_W  = 2;
	localparam int CAP_W = 7;

	localparam int STK_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int OPEN_W = $clog2(MAX_STACKS + 1);
	localparam int FILL_W = $clog2(MAX_CAPACITY + 1);
	localparam int SLOT_W = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
	localparam int DEPTH  = MAX_STACKS * MAX_CAPACITY;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_AT = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd4;

	typedef struct packed {
		logic [OP_W-1:0]         operation;
		logic signed [VAL_W-1:0] push_value;
		logic [IDX_W-1:0]        stack_index;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] pop_value;
		logic [ST_W-1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] slot_addr(logic [STK_W-1:0] k, logic [SLOT_W-1:0] s);
		return ADDR_W'(int'(k) * MAX_CAPACITY + int'(s));
	endfunction

endpackage

// ===== hw/rtl/set_of_bounded_stacks_top.sv =====
// Top level of the set of bounded stacks: controller, datapath and checks.
// A request passes through the execute state, which looks up the fill count
// of the chosen sub-stack and does the single value-memory write or read, and
// the response state, which moves the registered memory word into the output
// register. A new request is taken in the cycle its predecessor's result enters
// the output register; none is taken while a request is in the execute state.
// Every request gives exactly one response. stack_capacity is written through
// cfg_we/cfg_wdata; 0 acts as 1 and values above the sub-stack depth are clamped.
module set_of_bounded_stacks_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  sobs_pkg::req_t             req_data,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output sobs_pkg::rsp_t             rsp_data,
	input  logic                       cfg_we,
	input  logic [sobs_pkg::CAP_W-1:0] cfg_wdata
);
	import sobs_pkg::*;

	cmd_t cmd;

	sobs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	sobs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_data  (rsp_data)
	);

	// one request at a time: stall right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while previous one executes");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> ##3 rsp_valid)
		else $error("no response after accepted request");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_data.status != ST_OK)) |-> (rsp_data.pop_value == '0))
		else $error("failed request returned a nonzero value");

endmodule

// ===== hw/rtl/sobs_ctrl.sv =====
// Controller state machine: request capture, execute, response load.
module sobs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sobs_pkg::cmd_t     cmd
);
	import sobs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic       rsp_valid_q;
	logic       load_ok;
	logic       accept;

	assign load_ok   = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == S_IDLE) || ((state_q == S_RESP) && load_ok));
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	assign cmd.capture = accept;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.load    = (state_q == S_RESP) && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					// a new request may enter while the result drops into the output
					if (load_ok) state_q <= accept ? S_EXEC : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/sobs_dp.sv =====
// Datapath: fill counts, open count, value memory and result registers.
module sobs_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sobs_pkg::cmd_t               cmd,
	input  sobs_pkg::req_t               req_data,
	input  logic                         cfg_we,
	input  logic [sobs_pkg::CAP_W-1:0]   cfg_wdata,
	output sobs_pkg::rsp_t               rsp_data
);
	import sobs_pkg::*;

	logic [VAL_W-1:0]  mem_q [DEPTH];
	logic [FILL_W-1:0] fill_q [MAX_STACKS];
	logic [OPEN_W-1:0] open_q;
	logic [CAP_W-1:0]  cap_q;

	req_t              req_q;
	logic [ST_W-1:0]   st_q;
	logic              take_q;
	logic [VAL_W-1:0]  rdata_q;
	rsp_t              rsp_q;

	logic [FILL_W-1:0] eff_cap;
	logic [STK_W-1:0]  top_k;
	logic [STK_W-1:0]  at_k;
	logic [STK_W-1:0]  sel_k;
	logic [FILL_W-1:0] fill_k;

	logic [ST_W-1:0]   st_d;
	logic              take_d;
	logic              fill_we;
	logic [STK_W-1:0]  fill_wk;
	logic [FILL_W-1:0] fill_wd;
	logic [OPEN_W-1:0] open_d;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic              need_new;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = FILL_W'(1);
		end else if (int'(cap_q) > MAX_CAPACITY) begin
			eff_cap = FILL_W'(MAX_CAPACITY);
		end else begin
			eff_cap = FILL_W'(cap_q);
		end
	end

	assign top_k  = STK_W'(open_q - OPEN_W'(1));
	assign at_k   = STK_W'(req_q.stack_index - IDX_W'(1));
	assign sel_k  = (req_q.operation == OP_POP_AT) ? at_k : top_k;
	assign fill_k = (int'(sel_k) < MAX_STACKS) ? fill_q[sel_k] : '0;

	always_comb begin
		st_d     = ST_OK;
		take_d   = 1'b0;
		fill_we  = 1'b0;
		fill_wk  = sel_k;
		fill_wd  = fill_k;
		open_d   = open_q;
		mem_we   = 1'b0;
		mem_addr = slot_addr(sel_k, SLOT_W'(fill_k - FILL_W'(1)));
		need_new = (open_q == '0) || (fill_k >= eff_cap);
		unique case (req_q.operation)
			OP_PUSH: begin
				if (need_new) begin
					if (int'(open_q) >= MAX_STACKS) begin
						st_d = ST_OVERFLOW;
					end else begin
						// open a fresh sub-stack and put the value in its first slot
						fill_we  = 1'b1;
						fill_wk  = STK_W'(open_q);
						fill_wd  = FILL_W'(1);
						open_d   = open_q + OPEN_W'(1);
						mem_we   = 1'b1;
						mem_addr = slot_addr(STK_W'(open_q), '0);
					end
				end else begin
					fill_we  = 1'b1;
					fill_wd  = fill_k + FILL_W'(1);
					mem_we   = 1'b1;
					mem_addr = slot_addr(top_k, SLOT_W'(fill_k));
				end
			end
			OP_POP: begin
				if ((open_q == '0) || (fill_k == '0)) begin
					st_d = ST_UNDERFLOW;
				end else begin
					take_d  = 1'b1;
					fill_we = 1'b1;
					fill_wd = fill_k - FILL_W'(1);
					// drop the top sub-stack once it runs empty
					if (fill_k == FILL_W'(1)) open_d = open_q - OPEN_W'(1);
				end
			end
			OP_POP_AT: begin
				if ((req_q.stack_index == '0) || (int'(req_q.stack_index) > int'(open_q))) begin
					st_d = ST_BAD_INDEX;
				end else if (fill_k == '0) begin
					st_d = ST_UNDERFLOW;
				end else begin
					take_d  = 1'b1;
					fill_we = 1'b1;
					fill_wd = fill_k - FILL_W'(1);
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_STACKS; i++) fill_q[i] <= '0;
			open_q <= '0;
			cap_q  <= CAP_RESET;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.exec) begin
				open_q <= open_d;
				if (fill_we) fill_q[fill_wk] <= fill_wd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (mem_we) mem_q[mem_addr] <= req_q.push_value;
			rdata_q <= mem_q[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req_data;
		if (cmd.exec) begin
			st_q   <= st_d;
			take_q <= take_d;
		end
		if (cmd.load) begin
			rsp_q.pop_value <= take_q ? rdata_q : '0;
			rsp_q.status    <= st_q;
		end
	end

	assign rsp_data = rsp_q;

endmodule

// ===== tb/sv/set_of_bounded_stacks_top_tb.sv =====
// Self-checking testbench for the set of bounded stacks top level.
module set_of_bounded_stacks_top_tb;
	import sobs_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
	localparam int              IDLE_LIMIT = 2000;
	localparam int              N_ROWS     = 18;
	localparam int              N_PHASES   = 8;
	localparam int              PHASE_LEN  = 50;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] index;
		logic [7:0]       count;
		logic             typed;
		logic [VAL_W-1:0] exp_value;
		logic [ST_W-1:0]  exp_status;
	} step_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req_data = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp_data;
	logic             cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = CAP_RESET;

	// expectation typed into the table, carried alongside the request
	logic typed_now = 1'b0;
	rsp_t typed_rsp = '0;

	// shadow of the block's state
	logic signed [VAL_W-1:0] stack_mem [MAX_STACKS][MAX_CAPACITY];
	int                      stack_fill [MAX_STACKS];
	int                      open_cnt = 0;
	logic [CAP_W-1:0]        cap_shadow = CAP_RESET;

	rsp_t owed_q[$];
	int   n_taken = 0;
	int   n_answered = 0;
	int   n_errors = 0;
	int   idle_cycles = 0;
	bit   calm = 1'b0;

	step_row_t dir_rows [N_ROWS] = '{
		'{OP_POP,    32'h0,        5'd0,  8'd1, 1'b1, 32'h0, ST_UNDERFLOW},
		'{OP_POP_AT, 32'h0,        5'd0,  8'd1, 1'b1, 32'h0, ST_BAD_INDEX},
		'{OP_POP_AT, 32'h0,        5'd1,  8'd1, 1'b1, 32'h0, ST_BAD_INDEX},
		'{OP_PUSH,   32'h7FFFFFFF, 5'd0,  8'd1, 1'b1, 32'h0, ST_OK},
		'{OP_PUSH,   32'h80000000, 5'd31, 8'd1, 1'b1, 32'h0, ST_OK},
		'{OP_PUSH,   32'h0,        5'd0,  8'd1, 1'b1, 32'h0, ST_OK},
		'{OP_PUSH,   32'hFFFFFFFF, 5'd0,  8'd1, 1'b1, 32'h0, ST_OK},
		'{OP_PUSH,   32'h5,        5'd0,  8'd1, 1'b1, 32'h0, ST_OK},
		'{OP_POP_AT, 32'h0,        5'd1,  8'd1, 1'b0, 32'h0, ST_OK},
		'{OP_POP_AT, 32'h0,        5'd3,  8'd1, 1'b1, 32'h0, ST_BAD_INDEX},
		'{OP_POP_AT, 32'h0,        5'd31, 8'd1, 1'b1, 32'h0, ST_BAD_INDEX},
		'{OP_UNUSED, 32'hFFFFFFFF, 5'd31, 8'd1, 1'b1, 32'h0, ST_OK},
		'{OP_POP,    32'h0,        5'd0,  8'd1, 1'b0, 32'h0, ST_OK},
		'{OP_POP_AT, 32'h0,        5'd1,  8'd3, 1'b0, 32'h0, ST_OK},
		'{OP_POP_AT, 32'h0,        5'd1,  8'd1, 1'b1, 32'h0, ST_UNDERFLOW},
		'{OP_POP,    32'h0,        5'd0,  8'd1, 1'b1, 32'h0, ST_UNDERFLOW},
		'{OP_PUSH,   32'h7B,       5'd0,  8'd1, 1'b0, 32'h0, ST_OK},
		'{OP_POP,    32'h0,        5'd0,  8'd1, 1'b0, 32'h0, ST_OK}
	};

	int phase_cap [N_PHASES]  = '{0, 127, 1, 64, 2, 3, -1, 0};
	int phase_push [N_PHASES] = '{85, 30, 70, 45, 60, 25, 55, 50};

	set_of_bounded_stacks_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic rsp_t stack_step(input req_t r);
		rsp_t o;
		int   cap;
		int   k;
		o = '0;
		o.status = ST_OK;
		cap = (cap_shadow == 0) ? 1 :
			(int'(cap_shadow) > MAX_CAPACITY) ? MAX_CAPACITY : int'(cap_shadow);
		case (r.operation)
			OP_PUSH: begin
				if (open_cnt == 0 || stack_fill[open_cnt-1] >= cap) begin
					if (open_cnt >= MAX_STACKS)
						o.status = ST_OVERFLOW;
					else begin
						stack_fill[open_cnt] = 0;
						open_cnt++;
					end
				end
				if (o.status == ST_OK) begin
					k = open_cnt - 1;
					stack_mem[k][stack_fill[k]] = r.push_value;
					stack_fill[k]++;
				end
			end
			OP_POP: begin
				if (open_cnt == 0 || stack_fill[open_cnt-1] == 0)
					o.status = ST_UNDERFLOW;
				else begin
					k = open_cnt - 1;
					stack_fill[k]--;
					o.pop_value = stack_mem[k][stack_fill[k]];
					// drop the top sub-stack once it runs empty
					if (stack_fill[k] == 0)
						open_cnt--;
				end
			end
			OP_POP_AT: begin
				if (r.stack_index == 0 || int'(r.stack_index) > open_cnt)
					o.status = ST_BAD_INDEX;
				else if (stack_fill[r.stack_index-1] == 0)
					o.status = ST_UNDERFLOW;
				else begin
					k = int'(r.stack_index) - 1;
					stack_fill[k]--;
					o.pop_value = stack_mem[k][stack_fill[k]];
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return $urandom_range(15, 40);
		if (roll < 8)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic req_t random_request(input int push_pct);
		req_t r;
		int   roll;
		r.push_value = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: r.push_value = 32'h7FFFFFFF;
				1: r.push_value = 32'h80000000;
				2: r.push_value = 32'h0;
				default: r.push_value = 32'hFFFFFFFF;
			endcase
		end
		if ($urandom_range(0, 7) == 0)
			r.stack_index = $urandom_range(0, 31);
		else
			r.stack_index = $urandom_range(1, MAX_STACKS);
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			r.operation = OP_PUSH;
		else if (roll >= 97)
			r.operation = OP_UNUSED;
		else if ($urandom_range(0, 2) == 0)
			r.operation = OP_POP_AT;
		else
			r.operation = OP_POP;
		return r;
	endfunction

	// present one request and hold it until the block takes it
	task automatic send_request(input req_t r, input logic typed, input rsp_t t);
		int n;
		n = calm ? 0 : gap_len();
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		typed_now <= typed;
		typed_rsp <= t;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (n_answered != n_taken) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : scoreboard
		rsp_t owed;
		rsp_t model_rsp;
		logic took_req;
		logic took_rsp;
		took_req = req_valid && !req_stall;
		took_rsp = rsp_valid && !rsp_stall;
		if (arst_n) begin
			if (cfg_we)
				cap_shadow = cfg_wdata;
			if (took_req) begin
				model_rsp = stack_step(req_data);
				owed_q.insert(owed_q.size(), typed_now ? typed_rsp : model_rsp);
				n_taken++;
			end
			if (took_rsp) begin
				if (owed_q.size() == 0) begin
					$display("%0t: response with none owed: pop_value %h status %0d",
						$time, rsp_data.pop_value, rsp_data.status);
					n_errors++;
				end else begin
					owed = owed_q.pop_front();
					if (rsp_data.pop_value !== owed.pop_value) begin
						$display("%0t: pop_value expected %h, got %h",
							$time, owed.pop_value, rsp_data.pop_value);
						n_errors++;
					end
					if (rsp_data.status !== owed.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, owed.status, rsp_data.status);
						n_errors++;
					end
				end
				n_answered++;
			end
			idle_cycles = (took_req || took_rsp) ? 0 : idle_cycles + 1;
		end
	end

	initial begin : rsp_stall_gen
		int n;
		@(posedge clk);
		forever begin
			n = calm ? 0 : gap_len();
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		req_t             r;
		rsp_t             t;
		logic [CAP_W-1:0] cap;
		foreach (stack_fill[i])
			stack_fill[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			r.operation   = dir_rows[i].op;
			r.push_value  = dir_rows[i].value;
			r.stack_index = dir_rows[i].index;
			t.pop_value   = dir_rows[i].exp_value;
			t.status      = dir_rows[i].exp_status;
			repeat (dir_rows[i].count)
				send_request(r, dir_rows[i].typed, t);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			cap = (phase_cap[ph] < 0) ? CAP_W'($urandom_range(5, 63)) : CAP_W'(phase_cap[ph]);
			write_capacity(cap);
			calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_LEN; n++) begin
				// let the pipeline run dry halfway through the phase
				if (n == PHASE_LEN / 2) begin
					wait_drained();
					calm = ($urandom_range(0, 3) == 0);
				end
				send_request(random_request(phase_push[ph]), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (12) @(posedge clk);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== set_of_bounded_stacks_top.f =====
hw/rtl/sobs_pkg.sv
hw/rtl/sobs_ctrl.sv
hw/rtl/sobs_dp.sv
hw/rtl/set_of_bounded_stacks_top.sv
tb/sv/set_of_bounded_stacks_top_tb.sv
